// File: design/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY   = 32;
    localparam int VALUE_BITS = 32;

    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OPC_W     = 2;
    localparam int POS_W     = 8;
    localparam int IN_VAL_W  = 32;
    localparam int KIND_W    = 3;
    localparam int ELEM_W    = 32;
    localparam int IN_DATA_W = ((POS_W + IN_VAL_W + 7) / 8) * 8;
    localparam int CMP_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [OPC_W-1:0] {
        OP_DUMP   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ELEMENT     = 3'd0,
        KIND_EMPTY       = 3'd1,
        KIND_INSERTED    = 3'd2,
        KIND_FULL        = 3'd3,
        KIND_DELETED     = 3'd4,
        KIND_DEL_REFUSED = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_FOLLOW,
        RD_FRONT
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SOLO,
        WR_LINK1,
        WR_LINK2,
        WR_UNLINK
    } wr_mode_t;

    typedef struct packed {
        logic     capture;
        rd_sel_t  rd_sel;
        logic     steps_clr;
        logic     steps_inc;
        wr_mode_t wr_mode;
        logic     out_load;
        logic     out_dump;
        kind_t    out_kind;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    count_zero;
        logic    count_full;
        logic    k_in_range;
        logic    walk_done;
        logic    dump_last;
        logic    out_free;
    } dp_stat_t;

    function automatic logic [VALUE_BITS-1:0] to_stored(input logic [IN_VAL_W-1:0] v);
        logic [63:0] ext;
        ext = {{(64 - IN_VAL_W){v[IN_VAL_W-1]}}, v};
        return ext[VALUE_BITS-1:0];
    endfunction

    function automatic logic [ELEM_W-1:0] to_element(input logic [VALUE_BITS-1:0] s);
        logic [63:0] ext;
        ext = '0;
        ext[VALUE_BITS-1:0] = s;
        return ext[ELEM_W-1:0];
    endfunction

endpackage

// File: design/ple_ram.sv
`timescale 1ns / 1ps

module ple_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ple_ctrl.sv
`timescale 1ns / 1ps

module ple_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  ple_pkg::dp_stat_t   stat,
    output ple_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_SOLO,
        S_LINK1,
        S_LINK2,
        S_UNLINK,
        S_DUMP,
        S_REPLY
    } state_t;

    state_t              state_reg, state_next;
    ple_pkg::kind_t      kind_reg, kind_next;

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        cmd           = '0;
        cmd.rd_sel    = ple_pkg::RD_CUR;
        cmd.wr_mode   = ple_pkg::WR_NONE;
        cmd.out_kind  = kind_reg;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.capture   = s_axis_tvalid;
                if (s_axis_tvalid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.rd_sel    = ple_pkg::RD_FRONT;
                cmd.steps_clr = 1'b1;
                unique case (stat.op)
                    ple_pkg::OP_DUMP:
                    begin
                        if (stat.count_zero)
                        begin
                            kind_next  = ple_pkg::KIND_EMPTY;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            state_next = S_DUMP;
                        end
                    end
                    ple_pkg::OP_INSERT:
                    begin
                        if (stat.count_full)
                        begin
                            kind_next  = ple_pkg::KIND_FULL;
                            state_next = S_REPLY;
                        end
                        else if (stat.count_zero)
                        begin
                            state_next = S_SOLO;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    ple_pkg::OP_DELETE:
                    begin
                        if (stat.count_zero || !stat.k_in_range)
                        begin
                            kind_next  = ple_pkg::KIND_DEL_REFUSED;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = (stat.op == ple_pkg::OP_INSERT) ? S_LINK1 : S_UNLINK;
                end
                else
                begin
                    cmd.rd_sel    = ple_pkg::RD_FOLLOW;
                    cmd.steps_inc = 1'b1;
                end
            end
            S_SOLO:
            begin
                cmd.wr_mode = ple_pkg::WR_SOLO;
                kind_next   = ple_pkg::KIND_INSERTED;
                state_next  = S_REPLY;
            end
            S_LINK1:
            begin
                cmd.wr_mode = ple_pkg::WR_LINK1;
                state_next  = S_LINK2;
            end
            S_LINK2:
            begin
                cmd.wr_mode = ple_pkg::WR_LINK2;
                kind_next   = ple_pkg::KIND_INSERTED;
                state_next  = S_REPLY;
            end
            S_UNLINK:
            begin
                cmd.wr_mode = ple_pkg::WR_UNLINK;
                kind_next   = ple_pkg::KIND_DELETED;
                state_next  = S_REPLY;
            end
            S_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_dump  = 1'b1;
                    cmd.out_kind  = ple_pkg::KIND_ELEMENT;
                    cmd.rd_sel    = ple_pkg::RD_FOLLOW;
                    cmd.steps_inc = 1'b1;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= ple_pkg::KIND_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// File: design/ple_datapath.sv
`timescale 1ns / 1ps

module ple_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ple_pkg::dp_cmd_t                      cmd,
    output ple_pkg::dp_stat_t                     stat,
    input  logic [ple_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    input  logic [ple_pkg::OPC_W-1:0]             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [ple_pkg::ELEM_W-1:0]            m_axis_tdata,
    output logic [ple_pkg::KIND_W-1:0]            m_axis_tuser,
    output logic                                  m_axis_tlast
);

    logic [ple_pkg::OPC_W-1:0]      op_reg;
    logic [ple_pkg::POS_W-1:0]      pos_reg;
    logic [ple_pkg::IN_VAL_W-1:0]   value_reg;

    logic [ple_pkg::SLOT_W-1:0]     cur_reg;
    logic [ple_pkg::SLOT_W-1:0]     steps_reg, steps_next;
    logic [ple_pkg::SLOT_W-1:0]     front_reg, front_next;
    logic [ple_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [ple_pkg::CAPACITY-1:0]   used_reg, used_next;

    logic                           out_valid_reg;
    logic [ple_pkg::KIND_W-1:0]     out_kind_reg;
    logic [ple_pkg::ELEM_W-1:0]     out_elem_reg;
    logic                           out_last_reg;
    logic                           out_free;

    logic [ple_pkg::SLOT_W-1:0]     rd_addr;
    logic [ple_pkg::SLOT_W-1:0]     next_rd, prev_rd;
    logic [ple_pkg::VALUE_BITS-1:0] val_rd;

    logic                           next_we, prev_we, val_we;
    logic [ple_pkg::SLOT_W-1:0]     next_waddr, next_wdata, prev_waddr, prev_wdata;

    logic [ple_pkg::SLOT_W-1:0]     ns;
    logic [ple_pkg::POS_W-1:0]      k;
    logic                           k_in_range, at_front;
    logic [ple_pkg::SLOT_W-1:0]     walk_target;

    always_comb
    begin
        ns = '0;
        for (int i = ple_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                ns = ple_pkg::SLOT_W'(i);
            end
        end
    end

    assign k           = (pos_reg <= ple_pkg::POS_W'(1)) ? '0 : pos_reg - ple_pkg::POS_W'(1);
    assign k_in_range  = ple_pkg::CMP_W'(k) < ple_pkg::CMP_W'(count_reg);
    assign at_front    = (k == '0);
    assign walk_target = k_in_range ? k[ple_pkg::SLOT_W-1:0] : '0;
    assign out_free    = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        stat            = '0;
        stat.op         = ple_pkg::opcode_t'(op_reg);
        stat.count_zero = (count_reg == '0);
        stat.count_full = (count_reg == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
        stat.k_in_range = k_in_range;
        stat.walk_done  = (steps_reg == walk_target);
        stat.dump_last  = (ple_pkg::CNT_W'(steps_reg) + ple_pkg::CNT_W'(1)) == count_reg;
        stat.out_free   = out_free;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            ple_pkg::RD_FOLLOW: rd_addr = next_rd;
            ple_pkg::RD_FRONT:  rd_addr = front_reg;
            default:            rd_addr = cur_reg;
        endcase
    end

    always_comb
    begin
        steps_next = steps_reg;
        if (cmd.steps_clr)
        begin
            steps_next = '0;
        end
        else if (cmd.steps_inc)
        begin
            steps_next = steps_reg + ple_pkg::SLOT_W'(1);
        end
    end

    always_comb
    begin
        next_we    = 1'b0;
        prev_we    = 1'b0;
        val_we     = 1'b0;
        next_waddr = ns;
        next_wdata = ns;
        prev_waddr = ns;
        prev_wdata = ns;
        front_next = front_reg;
        count_next = count_reg;
        used_next  = used_reg;

        unique case (cmd.wr_mode)
            ple_pkg::WR_SOLO:
            begin
                next_we        = 1'b1;
                prev_we        = 1'b1;
                val_we         = 1'b1;
                front_next     = ns;
                count_next     = count_reg + ple_pkg::CNT_W'(1);
                used_next[ns]  = 1'b1;
            end
            ple_pkg::WR_LINK1:
            begin
                next_we    = 1'b1;
                next_waddr = prev_rd;
                prev_we    = 1'b1;
                prev_wdata = prev_rd;
                val_we     = 1'b1;
            end
            ple_pkg::WR_LINK2:
            begin
                next_we       = 1'b1;
                next_wdata    = cur_reg;
                prev_we       = 1'b1;
                prev_waddr    = cur_reg;
                count_next    = count_reg + ple_pkg::CNT_W'(1);
                used_next[ns] = 1'b1;
                if (at_front)
                begin
                    front_next = ns;
                end
            end
            ple_pkg::WR_UNLINK:
            begin
                next_we            = 1'b1;
                next_waddr         = prev_rd;
                next_wdata         = next_rd;
                prev_we            = 1'b1;
                prev_waddr         = next_rd;
                prev_wdata         = prev_rd;
                count_next         = count_reg - ple_pkg::CNT_W'(1);
                used_next[cur_reg] = 1'b0;
                if (cur_reg == front_reg)
                begin
                    front_next = next_rd;
                end
            end
            default:
            begin
            end
        endcase
    end

    ple_ram #(
        .WIDTH (ple_pkg::SLOT_W),
        .DEPTH (ple_pkg::CAPACITY)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rd)
    );

    ple_ram #(
        .WIDTH (ple_pkg::SLOT_W),
        .DEPTH (ple_pkg::CAPACITY)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_addr),
        .rdata (prev_rd)
    );

    ple_ram #(
        .WIDTH (ple_pkg::VALUE_BITS),
        .DEPTH (ple_pkg::CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (ns),
        .wdata (ple_pkg::to_stored(value_reg)),
        .raddr (rd_addr),
        .rdata (val_rd)
    );

    always_ff @(posedge clk)
    begin
        cur_reg   <= rd_addr;
        steps_reg <= steps_next;
        if (cmd.capture)
        begin
            op_reg    <= s_axis_tuser;
            pos_reg   <= s_axis_tdata[ple_pkg::POS_W-1:0];
            value_reg <= s_axis_tdata[ple_pkg::POS_W +: ple_pkg::IN_VAL_W];
        end
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_kind;
            out_elem_reg <= cmd.out_dump ? ple_pkg::to_element(val_rd) : '0;
            out_last_reg <= cmd.out_dump ? stat.dump_last : 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_elem_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
        else $error("element count above capacity");

    a_used_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(count_reg))
        else $error("slot usage map disagrees with element count");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output word overwritten before it was taken");

    a_alloc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_mode == ple_pkg::WR_SOLO || cmd.wr_mode == ple_pkg::WR_LINK2)
        |-> !used_reg[ns])
        else $error("allocated slot already in use");
`endif

endmodule

// File: design/positional_list_engine_top.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY values kept as a doubly linked ring in three
// slot RAMs (value, next link, prev link) with a usage map for free slots.
// One input word is taken at a time; the next is accepted once every result
// word of the current one has been handed to the output register. Insert and
// delete walk to k, the 0-based target position (0 when an insert appends):
// the walk follows one link per cycle through the registered read of the link
// RAMs, then an insert relinks in LINK1 and LINK2 (an insert into an empty
// list uses SOLO with no walk) and a delete in UNLINK, before the reply. A dump
// streams one element word per cycle while the output is drained; a dump of an
// empty list and every refusal give a single reply word. Opcode 3 is dropped
// with no result. No clearing pass is needed after reset.
module positional_list_engine_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ple_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // position[7:0], value[39:8]
    input  logic [ple_pkg::OPC_W-1:0]         s_axis_tuser,  // opcode[1:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ple_pkg::ELEM_W-1:0]        m_axis_tdata,  // element[31:0]
    output logic [ple_pkg::KIND_W-1:0]        m_axis_tuser,  // kind[2:0]
    output logic                              m_axis_tlast
);

    ple_pkg::dp_cmd_t  cmd;
    ple_pkg::dp_stat_t stat;

    ple_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    ple_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
